### rtl/core/cds_pkg.sv
`default_nettype none

package cds_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 16;
  localparam int STAT_W  = 2;
  // A year reduced modulo 400 fits in nine bits.
  localparam int YMOD_W  = 9;

  localparam logic [YEAR_W-1:0]  YEAR_TOP   = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0]  YEAR_CYCLE = YEAR_W'(400);
  localparam logic [YMOD_W-1:0]  YMOD_LAST  = YMOD_W'(399);
  localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_START = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_END   = 2'd2;
  localparam logic [STAT_W-1:0] ST_LIMIT     = 2'd3;

  // Status of the date presented to the day unit.
  typedef struct packed {
    logic               valid;
    logic               last_day;
    logic               year_wrap;
    logic [DAY_W-1:0]   next_day;
    logic [MONTH_W-1:0] next_month;
  } cds_day_info_t;

  // Leap year from the year modulo 400: the year modulo 4 and the test for
  // a whole century both follow from that remainder.
  function automatic logic leap_of(input logic [YMOD_W-1:0] rem);
    logic century;
    century = (rem == YMOD_W'(100)) || (rem == YMOD_W'(200)) || (rem == YMOD_W'(300));
    return (rem == '0) || ((rem[1:0] == 2'b00) && !century);
  endfunction

endpackage

`default_nettype wire

### rtl/core/cds_in_if.sv
`default_nettype none

interface cds_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [cds_pkg::DAY_W-1:0]    start_day;
  logic [cds_pkg::MONTH_W-1:0]  start_month;
  logic [cds_pkg::YEAR_W-1:0]   start_year;
  logic [cds_pkg::DAY_W-1:0]    end_day;
  logic [cds_pkg::MONTH_W-1:0]  end_month;
  logic [cds_pkg::YEAR_W-1:0]   end_year;
  logic [cds_pkg::COUNT_W-1:0]  day_offset;

  modport source (
    output valid, cmd, start_day, start_month, start_year,
           end_day, end_month, end_year, day_offset,
    input  ready
  );
  modport sink (
    input  valid, cmd, start_day, start_month, start_year,
           end_day, end_month, end_year, day_offset,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/cds_out_if.sv
`default_nettype none

interface cds_out_if;
  logic                         valid;
  logic                         ready;
  logic [cds_pkg::DAY_W-1:0]    result_day;
  logic [cds_pkg::MONTH_W-1:0]  result_month;
  logic [cds_pkg::YEAR_W-1:0]   result_year;
  logic [cds_pkg::COUNT_W-1:0]  day_count;
  logic [cds_pkg::STAT_W-1:0]   status;

  modport source (
    output valid, result_day, result_month, result_year, day_count, status,
    input  ready
  );
  modport sink (
    input  valid, result_day, result_month, result_year, day_count, status,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/cds_year_mod.sv
`default_nettype none

// Reduces a year modulo 400 by repeated subtraction, one subtraction a cycle.
module cds_year_mod (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [cds_pkg::YEAR_W-1:0]  year,
  output logic                             done,
  output logic [cds_pkg::YMOD_W-1:0]       rem
);

  logic [cds_pkg::YEAR_W-1:0] red_r, red_nxt;
  logic                       busy_r, busy_nxt;
  logic                       below;

  assign below = red_r < cds_pkg::YEAR_CYCLE;
  assign done  = busy_r && below;
  assign rem   = red_r[cds_pkg::YMOD_W-1:0];

  always_comb begin
    red_nxt  = red_r;
    busy_nxt = busy_r;
    if (start) begin
      red_nxt  = year;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (below) begin
        busy_nxt = 1'b0;
      end else begin
        red_nxt = red_r - cds_pkg::YEAR_CYCLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    red_r <= red_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/cds_day_unit.sv
`default_nettype none

// Month length, date check and the next calendar day for one date.
module cds_day_unit (
  input  wire logic [cds_pkg::DAY_W-1:0]    day,
  input  wire logic [cds_pkg::MONTH_W-1:0]  month,
  input  wire logic [cds_pkg::YEAR_W-1:0]   year,
  input  wire logic                         leap,
  output cds_pkg::cds_day_info_t            info
);

  localparam logic [cds_pkg::MONTH_W-1:0] M_FEB = 4'd2;
  localparam logic [cds_pkg::MONTH_W-1:0] M_APR = 4'd4;
  localparam logic [cds_pkg::MONTH_W-1:0] M_JUN = 4'd6;
  localparam logic [cds_pkg::MONTH_W-1:0] M_SEP = 4'd9;
  localparam logic [cds_pkg::MONTH_W-1:0] M_NOV = 4'd11;

  localparam logic [cds_pkg::DAY_W-1:0] LEN_28 = 5'd28;
  localparam logic [cds_pkg::DAY_W-1:0] LEN_29 = 5'd29;
  localparam logic [cds_pkg::DAY_W-1:0] LEN_30 = 5'd30;
  localparam logic [cds_pkg::DAY_W-1:0] LEN_31 = 5'd31;

  logic [cds_pkg::DAY_W-1:0] len;

  always_comb begin
    case (month)
      M_APR, M_JUN, M_SEP, M_NOV: len = LEN_30;
      M_FEB:                      len = leap ? LEN_29 : LEN_28;
      default:                    len = LEN_31;
    endcase
  end

  always_comb begin
    info.valid = (month != '0) && (month <= cds_pkg::MONTH_DEC) &&
                 (year != '0) && (year <= cds_pkg::YEAR_TOP) &&
                 (day != '0) && (day <= len);
    info.last_day  = (day >= len);
    info.year_wrap = info.last_day && (month >= cds_pkg::MONTH_DEC);
    if (!info.last_day) begin
      info.next_day   = day + 5'd1;
      info.next_month = month;
    end else if (!info.year_wrap) begin
      info.next_day   = 5'd1;
      info.next_month = month + 4'd1;
    end else begin
      info.next_day   = 5'd1;
      info.next_month = 4'd1;
    end
  end

endmodule

`default_nettype wire

### rtl/core/calendar_day_stepper.sv
`default_nettype none

// Channel  Dir  Beat contents
// in_ch    in   cmd, start date, end date, day_offset
// out_ch   out  result date, day_count, status
//
// An item steps at most 65535 days from its start date. The day stepper
// advances one calendar day a cycle; before that the year reduction unit
// reduces the year of each date it checks modulo 400.
// in_ch is ready only while the sequencer is idle; a finished result waits in
// the output register, and the sequencer holds it until out_ch frees it.
// Reset is synchronous and clears the sequencer and the output valid flag.
module calendar_day_stepper #(
  parameter int MAX_DAYS = 65535
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cds_in_if.sink    in_ch,
  cds_out_if.source out_ch
);

  localparam logic [cds_pkg::COUNT_W-1:0] LIMIT =
    (MAX_DAYS < 65535) ? cds_pkg::COUNT_W'(MAX_DAYS) : {cds_pkg::COUNT_W{1'b1}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MODS = 3'd1;
  localparam logic [2:0] S_MODE = 3'd2;
  localparam logic [2:0] S_STEP = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic                         cmd_r, cmd_nxt;
  logic [cds_pkg::DAY_W-1:0]    d_r, d_nxt, ed_r, ed_nxt;
  logic [cds_pkg::MONTH_W-1:0]  m_r, m_nxt, em_r, em_nxt;
  logic [cds_pkg::YEAR_W-1:0]   y_r, y_nxt, ey_r, ey_nxt;
  logic [cds_pkg::COUNT_W-1:0]  off_r, off_nxt, cnt_r, cnt_nxt;
  logic [cds_pkg::YMOD_W-1:0]   ym_r, ym_nxt;
  logic [cds_pkg::STAT_W-1:0]   st_r, st_nxt;

  logic                         ov_r, ov_nxt;
  logic [cds_pkg::DAY_W-1:0]    od_r, od_nxt;
  logic [cds_pkg::MONTH_W-1:0]  om_r, om_nxt;
  logic [cds_pkg::YEAR_W-1:0]   oy_r, oy_nxt;
  logic [cds_pkg::COUNT_W-1:0]  oc_r, oc_nxt;
  logic [cds_pkg::STAT_W-1:0]   os_r, os_nxt;

  logic                         accept;
  logic                         mod_start, mod_done;
  logic [cds_pkg::YEAR_W-1:0]   mod_year;
  logic [cds_pkg::YMOD_W-1:0]   mod_rem;

  logic [cds_pkg::DAY_W-1:0]    chk_day;
  logic [cds_pkg::MONTH_W-1:0]  chk_month;
  logic [cds_pkg::YEAR_W-1:0]   chk_year;
  logic                         chk_leap;
  cds_pkg::cds_day_info_t       info;
  logic                         hit;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = ov_r;
  assign out_ch.result_day   = od_r;
  assign out_ch.result_month = om_r;
  assign out_ch.result_year  = oy_r;
  assign out_ch.day_count    = oc_r;
  assign out_ch.status       = os_r;

  // The reduction unit serves the start year on acceptance and the end year
  // once the start date has been found good for a count command.
  assign mod_start = accept || ((state_r == S_MODS) && mod_done && info.valid && cmd_r);
  assign mod_year  = accept ? in_ch.start_year : ey_r;

  cds_year_mod u_year_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .year  (mod_year),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_comb begin
    if (state_r == S_MODE) begin
      chk_day   = ed_r;
      chk_month = em_r;
      chk_year  = ey_r;
    end else begin
      chk_day   = d_r;
      chk_month = m_r;
      chk_year  = y_r;
    end
    chk_leap = (state_r == S_STEP) ? cds_pkg::leap_of(ym_r) : cds_pkg::leap_of(mod_rem);
  end

  cds_day_unit u_day_unit (
    .day   (chk_day),
    .month (chk_month),
    .year  (chk_year),
    .leap  (chk_leap),
    .info  (info)
  );

  assign hit = cmd_r ? ((d_r == ed_r) && (m_r == em_r) && (y_r == ey_r))
                     : (cnt_r == off_r);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    d_nxt     = d_r;
    m_nxt     = m_r;
    y_nxt     = y_r;
    ed_nxt    = ed_r;
    em_nxt    = em_r;
    ey_nxt    = ey_r;
    off_nxt   = off_r;
    cnt_nxt   = cnt_r;
    ym_nxt    = ym_r;
    st_nxt    = st_r;
    ov_nxt    = ov_r && !out_ch.ready;
    od_nxt    = od_r;
    om_nxt    = om_r;
    oy_nxt    = oy_r;
    oc_nxt    = oc_r;
    os_nxt    = os_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_ch.cmd;
          d_nxt     = in_ch.start_day;
          m_nxt     = in_ch.start_month;
          y_nxt     = in_ch.start_year;
          ed_nxt    = in_ch.end_day;
          em_nxt    = in_ch.end_month;
          ey_nxt    = in_ch.end_year;
          off_nxt   = in_ch.day_offset;
          cnt_nxt   = '0;
          st_nxt    = cds_pkg::ST_OK;
          state_nxt = S_MODS;
        end
      end
      S_MODS: begin
        if (mod_done) begin
          ym_nxt = mod_rem;
          if (!info.valid) begin
            st_nxt    = cds_pkg::ST_BAD_START;
            d_nxt     = '0;
            m_nxt     = '0;
            y_nxt     = '0;
            state_nxt = S_DONE;
          end else if (cmd_r) begin
            state_nxt = S_MODE;
          end else begin
            state_nxt = S_STEP;
          end
        end
      end
      S_MODE: begin
        if (mod_done) begin
          if (!info.valid) begin
            st_nxt    = cds_pkg::ST_BAD_END;
            d_nxt     = '0;
            m_nxt     = '0;
            y_nxt     = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (hit) begin
          state_nxt = S_DONE;
        end else if ((cnt_r >= LIMIT) || (info.year_wrap && (y_r >= cds_pkg::YEAR_TOP))) begin
          st_nxt    = cds_pkg::ST_LIMIT;
          state_nxt = S_DONE;
        end else begin
          d_nxt   = info.next_day;
          m_nxt   = info.next_month;
          cnt_nxt = cnt_r + 16'd1;
          if (info.year_wrap) begin
            y_nxt  = y_r + 14'd1;
            ym_nxt = (ym_r == cds_pkg::YMOD_LAST) ? '0 : ym_r + 9'd1;
          end
        end
      end
      S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          od_nxt    = d_r;
          om_nxt    = m_r;
          oy_nxt    = y_r;
          oc_nxt    = cnt_r;
          os_nxt    = st_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    cmd_r <= cmd_nxt;
    d_r   <= d_nxt;
    m_r   <= m_nxt;
    y_r   <= y_nxt;
    ed_r  <= ed_nxt;
    em_r  <= em_nxt;
    ey_r  <= ey_nxt;
    off_r <= off_nxt;
    cnt_r <= cnt_nxt;
    ym_r  <= ym_nxt;
    st_r  <= st_nxt;
    od_r  <= od_nxt;
    om_r  <= om_nxt;
    oy_r  <= oy_nxt;
    oc_r  <= oc_nxt;
    os_r  <= os_nxt;
  end

  // The stepped date must stay a real date; this catches a slip in the
  // leap tracking carried by the year remainder.
  a_step_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> info.valid)
    else $error("stepped date is not a valid calendar date");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> (cnt_r <= LIMIT))
    else $error("day count ran past the step limit");

  a_accept_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_MODS))
    else $error("accepted beat did not start the start-date check");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !$past(ov_r)) |-> ($past(state_r) == S_DONE))
    else $error("result appeared without a finished item");

endmodule

`default_nettype wire
